[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// cond implies prop in the same cycle, outside reset
`define ASSERT_IMPLIES(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, cond, prop)

`endif

`endif

[sv/rcs_pkg.sv]
// ----------------------------------------------------------------------------
// rcs_pkg
// Constants, register indexes and helpers for the RGB to CMYK separation.
// ----------------------------------------------------------------------------
package rcs_pkg;

   localparam int unsigned PIX_W   = 17;
   localparam int unsigned INK_W   = 19;
   localparam int unsigned LANES   = 3;
   localparam int unsigned COLOR_W = 18;

   localparam logic [PIX_W-1:0] ONE_FX         = 17'h10000;
   localparam logic [PIX_W-1:0] NEAR_BLACK_LSB = 17'd6;
   localparam logic [INK_W-1:0] INK_RESET      = 19'h40000;

   typedef enum logic [0:0] {
      CSR_BLACK_GEN = 1'b0,
      CSR_TOTAL_INK = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pix_type;

   function automatic pix_type clamp_one(input pix_type v);
      return (v > ONE_FX) ? ONE_FX : v;
   endfunction

endpackage

[sv/rcs_div_pipe.sv]
// ----------------------------------------------------------------------------
// rcs_div_pipe
// Three-lane restoring divider with a shared divisor, one quotient bit per
// stage. Caller guarantees num_hi < den so QUO_W bits hold the quotient.
// ----------------------------------------------------------------------------
module rcs_div_pipe #(
   parameter int unsigned DEN_W  = 17,
   parameter int unsigned QUO_W  = 17,
   parameter int unsigned SIDE_W = 18
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [rcs_pkg::LANES-1:0][DEN_W-1:0]     num_hi,
   input  logic [rcs_pkg::LANES-1:0][QUO_W-1:0]     num_lo,
   input  logic [DEN_W-1:0]                         den,
   input  logic [SIDE_W-1:0]                        side_in,
   output logic                                     out_valid,
   output logic [rcs_pkg::LANES-1:0][QUO_W-1:0]     quo,
   output logic [SIDE_W-1:0]                        side_out
);

   localparam int unsigned L = rcs_pkg::LANES;

   logic                          valid_ff [QUO_W];
   logic [L-1:0][DEN_W-1:0]       rem_ff   [QUO_W];
   logic [L-1:0][QUO_W-1:0]       lo_ff    [QUO_W];
   logic [L-1:0][QUO_W-1:0]       quo_ff   [QUO_W];
   logic [DEN_W-1:0]              den_ff   [QUO_W];
   logic [SIDE_W-1:0]             side_ff  [QUO_W];

   logic                          src_valid [QUO_W];
   logic [L-1:0][DEN_W-1:0]       src_rem   [QUO_W];
   logic [L-1:0][QUO_W-1:0]       src_lo    [QUO_W];
   logic [L-1:0][QUO_W-1:0]       src_quo   [QUO_W];
   logic [DEN_W-1:0]              src_den   [QUO_W];
   logic [SIDE_W-1:0]             src_side  [QUO_W];
   logic [L-1:0][DEN_W-1:0]       rem_in    [QUO_W];
   logic [L-1:0][QUO_W-1:0]       lo_in     [QUO_W];
   logic [L-1:0][QUO_W-1:0]       quo_in    [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_valid[s] = in_valid;
         assign src_rem[s]   = num_hi;
         assign src_lo[s]    = num_lo;
         assign src_quo[s]   = '0;
         assign src_den[s]   = den;
         assign src_side[s]  = side_in;
      end else begin : g_next
         assign src_valid[s] = valid_ff[s-1];
         assign src_rem[s]   = rem_ff[s-1];
         assign src_lo[s]    = lo_ff[s-1];
         assign src_quo[s]   = quo_ff[s-1];
         assign src_den[s]   = den_ff[s-1];
         assign src_side[s]  = side_ff[s-1];
      end

      for (genvar l = 0; l < L; l++) begin : g_lane
         logic [DEN_W:0] trial;
         logic           ge;
         always_comb begin
            trial = {src_rem[s][l], src_lo[s][l][QUO_W-1]};
            ge    = (trial >= {1'b0, src_den[s]});
            // remainder stays below the divisor after the subtract
            rem_in[s][l] = ge ? DEN_W'(trial - {1'b0, src_den[s]}) : DEN_W'(trial);
            lo_in[s][l]  = {src_lo[s][l][QUO_W-2:0], 1'b0};
            quo_in[s][l] = {src_quo[s][l][QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= src_valid[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            lo_ff[s]   <= lo_in[s];
            quo_ff[s]  <= quo_in[s];
            den_ff[s]  <= src_den[s];
            side_ff[s] <= src_side[s];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

[sv/rgb_to_cmyk_separation.sv]
// ----------------------------------------------------------------------------
// rgb_to_cmyk_separation
// RGB pixel to CMYK plates with gray component replacement and ink limit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one RGB pixel per transfer, rsp_* one CMYK result per
//   transfer, in the same order. csr_* writes black_generation (index 0)
//   and total_ink (index 1); write only while no pixel is in flight.
// Pipeline: 41 register stages: 7 arithmetic stages plus two 17-stage
//   dividers (normalize by 1-k, then ink limit scaling), each producing one
//   quotient bit per stage.
// Throughput: one pixel per clock; a new pixel can enter every cycle unless stalled.
// Reset: clears all stage valid bits and loads black_generation = 1.0,
//   total_ink = 4.0.
// Stall: when rsp_tvalid is high and rsp_tready low, the whole pipeline
//   holds and req_tready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_cmyk_separation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // red[16:0], green[33:17], blue[50:34], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // cyan[16:0], magenta[33:17], yellow[50:34],
                                    // black[67:51], zero pad
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [18:0] csr_wdata
);

   localparam int unsigned PW = rcs_pkg::PIX_W;
   localparam int unsigned IW = rcs_pkg::INK_W;
   localparam int unsigned CW = rcs_pkg::COLOR_W;
   localparam int unsigned L  = rcs_pkg::LANES;

   logic en;

   // configuration
   logic [PW-1:0] bg_ff;
   logic [IW-1:0] ink_ff;
   logic [PW-1:0] bg_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff  <= rcs_pkg::ONE_FX;
         ink_ff <= rcs_pkg::INK_RESET;
      end else if (csr_we) begin
         unique case (rcs_pkg::csr_index_type'(csr_addr))
            rcs_pkg::CSR_BLACK_GEN: bg_ff  <= csr_wdata[PW-1:0];
            rcs_pkg::CSR_TOTAL_INK: ink_ff <= csr_wdata;
            default:                bg_ff  <= bg_ff;
         endcase
      end
   end

   assign bg_clamped = rcs_pkg::clamp_one(bg_ff);

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: clamp and mirror
   logic                v1_ff;
   logic [L-1:0][PW-1:0] plate1_ff, plate1_in;

   always_comb begin
      for (int l = 0; l < L; l++) begin
         plate1_in[l] = rcs_pkg::ONE_FX - rcs_pkg::clamp_one(req_tdata[l*PW +: PW]);
      end
   end

   // stage 2: minimum of the raw plates
   logic                v2_ff;
   logic [L-1:0][PW-1:0] plate2_ff;
   logic [PW-1:0]        lo2_ff, lo2_in;

   always_comb begin
      lo2_in = plate1_ff[0];
      if (plate1_ff[1] < lo2_in) lo2_in = plate1_ff[1];
      if (plate1_ff[2] < lo2_in) lo2_in = plate1_ff[2];
   end

   // stage 3: black = min * black_generation
   logic                 v3_ff;
   logic [L-1:0][PW-1:0] plate3_ff;
   logic [PW-1:0]        k3_ff;
   logic [2*PW-1:0]      kprod3;

   assign kprod3 = lo2_ff * bg_clamped;

   // stage 4: plate - k, 1 - k
   logic                 v4_ff;
   logic [L-1:0][PW-1:0] diff4_ff, diff4_in;
   logic [PW-1:0]        d4_ff, k4_ff, d4_in;
   logic                 near4_ff;

   always_comb begin
      d4_in = rcs_pkg::ONE_FX - k3_ff;
      for (int l = 0; l < L; l++) begin
         diff4_in[l] = plate3_ff[l] - k3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plate1_ff <= plate1_in;
         plate2_ff <= plate1_ff;
         lo2_ff    <= lo2_in;
         plate3_ff <= plate2_ff;
         k3_ff     <= kprod3[PW+15:16];
         diff4_ff  <= diff4_in;
         d4_ff     <= d4_in;
         k4_ff     <= k3_ff;
         near4_ff  <= (d4_in <= rcs_pkg::NEAR_BLACK_LSB);
      end
   end

   // divider A: (plate - k) * 2^16 / (1 - k)
   logic [L-1:0][PW-1:0] numa_hi, numa_lo, qa;
   logic                 va;
   logic [PW:0]          sidea;

   always_comb begin
      for (int l = 0; l < L; l++) begin
         numa_hi[l] = {1'b0, diff4_ff[l][PW-1:1]};
         numa_lo[l] = {diff4_ff[l][0], 16'd0};
      end
   end

   rcs_div_pipe #(
      .DEN_W  (17),
      .QUO_W  (17),
      .SIDE_W (18)
   ) u_div_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .num_hi    (numa_hi),
      .num_lo    (numa_lo),
      .den       (d4_ff),
      .side_in   ({near4_ff, k4_ff}),
      .out_valid (va),
      .quo       (qa),
      .side_out  (sidea)
   );

   // stage 5: near-black override, colour sum
   logic                 v5_ff;
   logic [L-1:0][PW-1:0] c5_ff, c5_in;
   logic [PW-1:0]        k5_ff;
   logic [CW-1:0]        col5_ff, col5_in;

   always_comb begin
      for (int l = 0; l < L; l++) begin
         c5_in[l] = sidea[PW] ? '0 : qa[l];
      end
      col5_in = CW'(c5_in[0]) + CW'(c5_in[1]) + CW'(c5_in[2]);
   end

   // stage 6: limit test and remaining headroom
   logic                 v6_ff;
   logic [L-1:0][PW-1:0] c6_ff;
   logic [PW-1:0]        k6_ff;
   logic [CW-1:0]        col6_ff;
   logic [IW-1:0]        lim6_ff, tot6, lim6_in;
   logic                 apply6_ff, apply6_in;

   always_comb begin
      tot6      = IW'(col5_ff) + IW'(k5_ff);
      apply6_in = (col5_ff != '0) && (tot6 > ink_ff);
      lim6_in   = (ink_ff > IW'(k5_ff)) ? ink_ff - IW'(k5_ff) : '0;
   end

   // stage 7: plate * limit; unlimited pixels divide c*1 by 1
   logic                    v7_ff;
   logic [L-1:0][PW+IW-1:0] prod7_ff, prod7_in;
   logic [CW-1:0]           den7_ff, den7_in;
   logic [PW-1:0]           k7_ff;
   logic [IW-1:0]           mul7;

   always_comb begin
      mul7    = apply6_ff ? lim6_ff : IW'(1);
      den7_in = apply6_ff ? col6_ff : CW'(1);
      for (int l = 0; l < L; l++) begin
         prod7_in[l] = c6_ff[l] * mul7;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= va;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c5_ff     <= c5_in;
         k5_ff     <= sidea[PW-1:0];
         col5_ff   <= col5_in;
         c6_ff     <= c5_ff;
         k6_ff     <= k5_ff;
         col6_ff   <= col5_ff;
         lim6_ff   <= lim6_in;
         apply6_ff <= apply6_in;
         prod7_ff  <= prod7_in;
         den7_ff   <= den7_in;
         k7_ff     <= k6_ff;
      end
   end

   // divider B: plate * limit / colour sum; product stays below 2^35
   logic [L-1:0][CW-1:0] numb_hi;
   logic [L-1:0][PW-1:0] numb_lo, qb;
   logic                 vb;
   logic [PW-1:0]        kb;

   always_comb begin
      for (int l = 0; l < L; l++) begin
         numb_hi[l] = prod7_ff[l][PW+CW-1:PW];
         numb_lo[l] = prod7_ff[l][PW-1:0];
      end
   end

   rcs_div_pipe #(
      .DEN_W  (18),
      .QUO_W  (17),
      .SIDE_W (17)
   ) u_div_limit (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .num_hi    (numb_hi),
      .num_lo    (numb_lo),
      .den       (den7_ff),
      .side_in   (k7_ff),
      .out_valid (vb),
      .quo       (qb),
      .side_out  (kb)
   );

   assign rsp_tvalid = vb;
   assign rsp_tdata  = {4'd0, kb, qb[2], qb[1], qb[0]};

   `ASSERT_IMPLIES(a_stall_holds_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `ASSERT_IMPLIES(a_black_range, clock, reset, rsp_tvalid, rsp_tdata[67:51] <= rcs_pkg::ONE_FX)
   `ASSERT_IMPLIES(a_cyan_range, clock, reset, rsp_tvalid, rsp_tdata[16:0] <= rcs_pkg::ONE_FX)

endmodule
